// ===== rtl/core/chunk_size_line_parser_assert.svh =====
// Assertion macros used by the checker file (csl_checker.sv).
// All properties are sampled on aclk and are off while aresetn is low.
`ifndef CHUNK_SIZE_LINE_PARSER_ASSERT_SVH
`define CHUNK_SIZE_LINE_PARSER_ASSERT_SVH

// Same-cycle implication.
`define CSL_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/csl_pkg.sv =====
`default_nettype none
package csl_pkg;

    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_SEMI = 8'h3B;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_INCOMPLETE = 3'd1;
    localparam logic [2:0] ST_TOO_LONG   = 3'd2;
    localparam logic [2:0] ST_EXTENSION  = 3'd3;
    localparam logic [2:0] ST_BAD_DIGIT  = 3'd4;
    localparam logic [2:0] ST_OVERFLOW   = 3'd5;

    typedef struct packed {
        logic [31:0] size_acc;
        logic [3:0]  byte_count;
        logic        pend_cr;
        logic        saw_semi;
        logic        saw_non_hex;
    } line_state_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] length;
        logic [3:0]  consumed;
    } parse_result_t;

    // {is_hex, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/csl_step.sv =====
`default_nettype none
module csl_step
    import csl_pkg::*;
#(
    parameter int MAX_DIGITS = 8,
    parameter int SCAN_LIMIT = 10
) (
    input  line_state_t   cur_state,
    input  logic [7:0]    data_byte,
    input  logic          last_byte,
    output line_state_t   next_state,
    output parse_result_t result,
    output logic          result_valid
);

    logic [4:0] hex;
    logic [3:0] digits;
    logic [4:0] used_sum;

    assign hex      = hex_decode(data_byte);
    // pending CR is counted in byte_count, so digits = count - 1
    assign digits   = cur_state.byte_count - 4'd1;
    assign used_sum = {1'b0, digits} + 5'd2;

    always_comb begin
        next_state   = cur_state;
        result       = '0;
        result_valid = 1'b0;

        if (cur_state.pend_cr && data_byte == CHAR_LF) begin
            result_valid = 1'b1;
            if (cur_state.saw_semi) begin
                result.status = ST_EXTENSION;
            end else if (cur_state.saw_non_hex) begin
                result.status = ST_BAD_DIGIT;
            end else if ({1'b0, digits} > 5'(MAX_DIGITS)) begin
                result.status = ST_OVERFLOW;
            end else begin
                result.status   = ST_OK;
                result.length   = cur_state.size_acc;
                result.consumed = used_sum[3:0];
            end
            next_state = '0;
        end else begin
            // a CR not followed by LF is an ordinary bad byte
            if (cur_state.pend_cr) begin
                next_state.saw_non_hex = 1'b1;
                next_state.pend_cr     = 1'b0;
            end
            if (cur_state.byte_count < 4'(SCAN_LIMIT)) begin
                next_state.byte_count = cur_state.byte_count + 4'd1;
            end
            if (data_byte == CHAR_CR) begin
                next_state.pend_cr = 1'b1;
            end else if (data_byte == CHAR_SEMI) begin
                next_state.saw_semi    = 1'b1;
                next_state.saw_non_hex = 1'b1;
            end else if (hex[4]) begin
                next_state.size_acc = {cur_state.size_acc[27:0], hex[3:0]};
            end else begin
                next_state.saw_non_hex = 1'b1;
            end
            if (last_byte) begin
                result_valid  = 1'b1;
                result.status = (next_state.byte_count >= 4'(SCAN_LIMIT)) ?
                                ST_TOO_LONG : ST_INCOMPLETE;
                next_state    = '0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/chunk_size_line_parser.sv =====
// Chunk-size line parser for chunked HTTP/1.1 bodies.
// s_ channel: one raw line byte per transaction (s_data_byte), with
//   s_last_byte marking the end of the bytes available so far.
// m_ channel: one result per finished line (CR LF) or per s_last_byte:
//   m_parse_status, m_chunk_length (hex value when ok), m_consumed_bytes
//   (digits + 2 when ok). Bytes that neither finish a line nor carry s_last_byte give no result.
// Throughput: one byte per cycle while s_ready is high. Each byte is decoded
//   by one stage of logic (hex decode, 4-bit shift-in, flag update) between
//   the line state registers and the result register.
// Latency: a result appears on m_ the cycle after the byte that causes it
//   is accepted.
// Stall: s_ready is high while the result register is empty or being
//   taken; a held result blocks every byte until m_ready takes it.
// Reset (aresetn low, synchronous): line state is cleared and no result
//   is pending. Line state also clears after every result.
`default_nettype none
module chunk_size_line_parser
    import csl_pkg::*;
#(
    parameter int MAX_DIGITS = 8,
    parameter int SCAN_LIMIT = 10
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_last_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_parse_status,
    output logic [31:0]      m_chunk_length,
    output logic [3:0]       m_consumed_bytes
);

    line_state_t   state_reg;
    line_state_t   state_next;
    parse_result_t result_reg;
    parse_result_t result_next;
    logic          result_fire;
    logic          m_valid_reg;
    logic          s_accept;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    csl_step #(
        .MAX_DIGITS (MAX_DIGITS),
        .SCAN_LIMIT (SCAN_LIMIT)
    ) u_step (
        .cur_state    (state_reg),
        .data_byte    (s_data_byte),
        .last_byte    (s_last_byte),
        .next_state   (state_next),
        .result       (result_next),
        .result_valid (result_fire)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                state_reg <= state_next;
            end
            if (s_accept && result_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && result_fire) begin
            result_reg <= result_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_parse_status   = result_reg.status;
    assign m_chunk_length   = result_reg.length;
    assign m_consumed_bytes = result_reg.consumed;

endmodule
`default_nettype wire

// ===== rtl/core/csl_checker.sv =====
`default_nettype none
`include "chunk_size_line_parser_assert.svh"
module csl_checker
    import csl_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [2:0]  m_parse_status,
    input wire logic [31:0] m_chunk_length,
    input wire logic [3:0]  m_consumed_bytes
);

    // stalled result transaction holds
    `CSL_ASSERT_NEXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_parse_status) && $stable(m_chunk_length) && $stable(m_consumed_bytes), "stalled result changed")

    // error statuses carry no length or byte count
    `CSL_ASSERT_IMPL(a_error_zero, m_valid && m_parse_status != ST_OK, m_chunk_length == 32'd0 && m_consumed_bytes == 4'd0, "error result with nonzero fields")

    // ok always includes the CR LF pair, unless the 4-bit count wrapped
    `CSL_ASSERT_IMPL(a_ok_consumed, m_valid && m_parse_status == ST_OK, m_consumed_bytes >= 4'd2 || m_consumed_bytes == 4'd0, "ok result with short byte count")

    // an empty result register never blocks input
    `CSL_ASSERT_IMPL(a_ready_empty, !m_valid, s_ready, "input stalled with no pending result")

    // a drained result register keeps input open in the next cycle
    `CSL_ASSERT_NEXT(a_ready_after_take, m_valid && m_ready && !(s_valid && s_ready), s_ready && !m_valid, "result not cleared after transaction")

endmodule

bind chunk_size_line_parser csl_checker u_csl_checker (.*);
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import csl_pkg::*;

    localparam int MAX_DIGITS   = 8;
    localparam int SCAN_LIMIT   = 10;
    localparam int ITEMS        = 1250;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int NUM_DIRECTED = 31;

    typedef struct packed {
        logic [7:0]    data;
        logic          last;
        logic          typed;
        parse_result_t res;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_parse_status;
    logic [31:0] m_chunk_length;
    logic [3:0]  m_consumed_bytes;

    // line state mirrored by the predictor
    logic [31:0] line_acc = '0;
    logic [3:0]  line_count = '0;
    logic        cr_pending = 1'b0;
    logic        semi_seen = 1'b0;
    logic        non_hex_seen = 1'b0;

    parse_result_t pending_results [$];
    int fail_count = 0;
    int bytes_sent = 0;
    int cycle_count = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;

    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{8'h41, 1'b1, 1'b1, '{ST_INCOMPLETE, 32'h0, 4'd0}},
        // empty line, last set on the LF is ignored
        '{CHAR_CR, 1'b0, 1'b0, '0},
        '{CHAR_LF, 1'b1, 1'b1, '{ST_OK, 32'h0, 4'd2}},
        '{8'h66, 1'b0, 1'b0, '0},
        '{8'h66, 1'b0, 1'b0, '0},
        '{8'h66, 1'b0, 1'b0, '0},
        '{8'h66, 1'b0, 1'b0, '0},
        '{8'h66, 1'b0, 1'b0, '0},
        '{8'h66, 1'b0, 1'b0, '0},
        '{8'h66, 1'b0, 1'b0, '0},
        '{8'h66, 1'b0, 1'b0, '0},
        '{CHAR_CR, 1'b0, 1'b0, '0},
        '{CHAR_LF, 1'b0, 1'b1, '{ST_OK, 32'hFFFF_FFFF, 4'd10}},
        // extension, with a CR that is not followed by LF
        '{CHAR_SEMI, 1'b0, 1'b0, '0},
        '{CHAR_CR, 1'b0, 1'b0, '0},
        '{CHAR_CR, 1'b0, 1'b0, '0},
        '{CHAR_LF, 1'b0, 1'b1, '{ST_EXTENSION, 32'h0, 4'd0}},
        // lone LF is just a bad byte
        '{CHAR_LF, 1'b0, 1'b0, '0},
        '{CHAR_CR, 1'b0, 1'b0, '0},
        '{CHAR_LF, 1'b0, 1'b1, '{ST_BAD_DIGIT, 32'h0, 4'd0}},
        // nine digits: value shifts out, count reaches the scan limit
        '{8'h31, 1'b0, 1'b0, '0},
        '{8'h32, 1'b0, 1'b0, '0},
        '{8'h33, 1'b0, 1'b0, '0},
        '{8'h34, 1'b0, 1'b0, '0},
        '{8'h35, 1'b0, 1'b0, '0},
        '{8'h36, 1'b0, 1'b0, '0},
        '{8'h37, 1'b0, 1'b0, '0},
        '{8'h38, 1'b0, 1'b0, '0},
        '{8'h39, 1'b0, 1'b0, '0},
        '{CHAR_CR, 1'b0, 1'b0, '0},
        '{CHAR_LF, 1'b0, 1'b1, '{ST_OVERFLOW, 32'h0, 4'd0}}
    };

    chunk_size_line_parser #(
        .MAX_DIGITS(MAX_DIGITS),
        .SCAN_LIMIT(SCAN_LIMIT)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data_byte(s_data_byte),
        .s_last_byte(s_last_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_parse_status(m_parse_status),
        .m_chunk_length(m_chunk_length),
        .m_consumed_bytes(m_consumed_bytes)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Advances the mirrored line state by one byte; returns 1 when a result is due.
    function automatic bit advance_line(input logic [7:0] b, input logic fin,
                                        output parse_result_t r);
        logic [3:0] digits;
        logic [3:0] nib;
        bit         is_hex;
        r = '0;
        if (cr_pending && b == CHAR_LF) begin
            digits = line_count - 4'd1;
            if (semi_seen)
                r.status = ST_EXTENSION;
            else if (non_hex_seen)
                r.status = ST_BAD_DIGIT;
            else if (digits > MAX_DIGITS)
                r.status = ST_OVERFLOW;
            else
                r = '{ST_OK, line_acc, digits + 4'd2};
            {line_acc, line_count, cr_pending, semi_seen, non_hex_seen} = '0;
            return 1'b1;
        end
        if (cr_pending) begin
            non_hex_seen = 1'b1;
            cr_pending = 1'b0;
        end
        if (line_count < SCAN_LIMIT)
            line_count++;
        is_hex = 1'b1;
        nib = b[3:0];
        if (b >= 8'h30 && b <= 8'h39) begin
            nib = b[3:0];
        end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
            nib = b[3:0] + 4'd9;
        end else begin
            is_hex = 1'b0;
        end
        if (b == CHAR_CR) begin
            cr_pending = 1'b1;
        end else if (b == CHAR_SEMI) begin
            semi_seen = 1'b1;
            non_hex_seen = 1'b1;
        end else if (is_hex) begin
            line_acc = {line_acc[27:0], nib};
        end else begin
            non_hex_seen = 1'b1;
        end
        if (fin) begin
            r.status = (line_count >= SCAN_LIMIT) ? ST_TOO_LONG : ST_INCOMPLETE;
            {line_acc, line_count, cr_pending, semi_seen, non_hex_seen} = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Offers one byte from a falling edge, returns at the falling edge after acceptance.
    task automatic send_byte(input logic [7:0] d, input logic fin, input logic typed,
                             input parse_result_t typed_res);
        int            gap;
        parse_result_t r;
        gap = 0;
        while ($urandom_range(0, 99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= d;
        s_last_byte <= fin;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        if (advance_line(d, fin, r)) begin
            if (typed)
                pending_results = {pending_results, typed_res};
            else
                pending_results = {pending_results, r};
        end
        @(negedge aclk);
    endtask

    // Mostly well-formed size lines with random content, some noise and cut-off lines.
    task automatic send_random_line();
        int         n;
        int         roll;
        bit         trunc;
        logic       fin;
        logic [7:0] b;
        logic [3:0] v;
        if ($urandom_range(0, 99) < 8) begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b0, '0);
            return;
        end
        n = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8) : $urandom_range(9, 14);
        trunc = $urandom_range(0, 99) < 10;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(0, 99);
            v = 4'($urandom_range(0, 15));
            if (v < 10)
                b = 8'h30 + v;
            else
                b = ($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 8'd10;
            if (roll < 3)
                b = CHAR_SEMI;
            else if (roll < 6)
                b = 8'($urandom_range(0, 255));
            else if (roll < 8)
                b = CHAR_CR;
            fin = (trunc && i == n - 1) || $urandom_range(0, 99) < 2;
            send_byte(b, fin, 1'b0, '0);
            if (fin)
                return;
        end
        send_byte(CHAR_CR, 1'b0, 1'b0, '0);
        send_byte(CHAR_LF, $urandom_range(0, 9) == 0, 1'b0, '0);
    endtask

    // Result side: random stalls plus one long hold-off on request.
    always @(negedge aclk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        parse_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction: status %0d length %h consumed %0d",
                       m_parse_status, m_chunk_length, m_consumed_bytes);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_parse_status !== want.status) begin
                    $error("parse_status: expected %0d, got %0d", want.status, m_parse_status);
                    fail_count++;
                end
                if (m_chunk_length !== want.length) begin
                    $error("chunk_length: expected %h, got %h", want.length, m_chunk_length);
                    fail_count++;
                end
                if (m_consumed_bytes !== want.consumed) begin
                    $error("consumed_bytes: expected %0d, got %0d",
                           want.consumed, m_consumed_bytes);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        tx_idle_pct = 31;
        rx_idle_pct = 76;
        foreach (directed_rows[i])
            send_byte(directed_rows[i].data, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].res);
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct = 31;
                    rx_idle_pct = 76;
                end
                1: begin
                    tx_idle_pct = 76;
                    rx_idle_pct = 31;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    // long receiver stall while bytes keep coming
                    hold_requests++;
                end
            endcase
            while (bytes_sent < (ph + 1) * ITEMS / 3)
                send_random_line();
        end
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== chunk_size_line_parser.f =====
+incdir+rtl/core
rtl/core/csl_pkg.sv
rtl/core/csl_step.sv
rtl/core/chunk_size_line_parser.sv
rtl/core/csl_checker.sv
verif/testbench.sv
